FILE: rtl/crd_pkg.sv
package crd_pkg;

   localparam int SAMPLE_WIDTH    = 32;
   localparam int ALPHA_WIDTH     = 17;
   localparam int THRESHOLD_WIDTH = 39;
   localparam int WARMUP_WIDTH    = 16;
   localparam int COUNT_WIDTH     = 32;
   localparam int REGIME_WIDTH    = 2;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 39;

   // alpha is walked four bits at a time, most significant digit first
   localparam int DIGIT_WIDTH       = 4;
   localparam int DIGIT_COUNT       = 5;
   localparam int DIGIT_COUNT_WIDTH = 3;
   localparam int ALPHA_PAD_WIDTH   = DIGIT_WIDTH * DIGIT_COUNT;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef enum logic [REGIME_WIDTH-1:0] {
      REGIME_STABLE = 2'd0,
      REGIME_ACCEL  = 2'd1,
      REGIME_DECEL  = 2'd2
   } regime_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ALPHA_FIRST  = 2'd0,
      CSR_ALPHA_SECOND = 2'd1,
      CSR_THRESHOLD    = 2'd2,
      CSR_WARMUP       = 2'd3
   } csr_index_type;

   localparam logic [ALPHA_WIDTH-1:0]     ALPHA_FIRST_RESET  = 17'd16384;
   localparam logic [ALPHA_WIDTH-1:0]     ALPHA_SECOND_RESET = 17'd16384;
   localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET    = 39'd6554;
   localparam logic [WARMUP_WIDTH-1:0]    WARMUP_RESET       = 16'd3;

endpackage

FILE: rtl/crd_mul.sv
// Digit-serial multiplier: step = floor(diff * alpha / 2^FRAC_BITS).
// One 4-bit digit of alpha per cycle, done pulses in the cycle after the last digit.
module crd_mul #(
   parameter int RATE_WIDTH = 40,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [RATE_WIDTH:0]          diff,
   input  logic [crd_pkg::ALPHA_WIDTH-1:0]     alpha,
   output logic                                done,
   output logic signed [RATE_WIDTH:0]          step
);

   localparam int PAD_W  = crd_pkg::ALPHA_PAD_WIDTH;
   localparam int ACC_W  = RATE_WIDTH + 1 + PAD_W;
   localparam int PROD_W = RATE_WIDTH + crd_pkg::DIGIT_WIDTH + 2;
   localparam int CNT_W  = crd_pkg::DIGIT_COUNT_WIDTH;

   logic signed [RATE_WIDTH:0]           diff_ff;
   logic [PAD_W-1:0]                     alpha_ff;
   logic [PAD_W-1:0]                     alpha_in;
   logic [CNT_W-1:0]                     count_ff;
   logic                                 busy_ff;
   logic                                 done_ff;
   logic signed [ACC_W-1:0]              acc_ff;
   logic signed [ACC_W-1:0]              acc_in;
   logic [crd_pkg::DIGIT_WIDTH-1:0]      digit;
   logic signed [PROD_W-1:0]             prod;

   assign digit    = alpha_ff[PAD_W-1 -: crd_pkg::DIGIT_WIDTH];
   assign prod     = PROD_W'(diff_ff) * PROD_W'($signed({1'b0, digit}));
   assign acc_in   = (acc_ff <<< crd_pkg::DIGIT_WIDTH) + ACC_W'(prod);
   assign alpha_in = alpha_ff << crd_pkg::DIGIT_WIDTH;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (count_ff == '0);
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(crd_pkg::DIGIT_COUNT - 1);
            acc_ff   <= '0;
            alpha_ff <= PAD_W'(alpha);
            diff_ff  <= diff;
         end else if (busy_ff) begin
            acc_ff   <= acc_in;
            alpha_ff <= alpha_in;
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   // arithmetic shift gives the floor; magnitude never exceeds |diff| while alpha is at most 2^FRAC_BITS
   assign step = (RATE_WIDTH + 1)'(acc_ff >>> FRAC_BITS);

endmodule

FILE: rtl/convexity_regime_detector_unit.sv
// Convexity regime detector. Each req transaction (tuser = operation, tdata = Q16.16
// sample) gives exactly one rsp transaction carrying both smoothed rates, the regime,
// a change flag and the two saturating counters. A clear or the first sample of a run
// goes from idle straight to the output state, where its result is loaded; the second
// sample passes the raw-difference state first, and every later sample runs two EMA
// updates one after another through a single shared add/saturate unit and a
// digit-serial multiplier that takes 5 digits of alpha. The input is ready again the
// cycle after the load. The input is not ready while an item is being
// worked on; a loaded result waits in the output register while the next item is
// accepted, and a result that finds the register still full holds the block until it
// drains. Register writes on the csr port clear all statistics; issue them only while
// no transaction is in flight, and the input is not ready in a cycle with a write.
module convexity_regime_detector_unit #(
   parameter int RATE_WIDTH = 40,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [crd_pkg::SAMPLE_WIDTH-1:0]           req_tdata,  // sample
   input  logic                                       req_tuser,  // operation
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // first_rate, second_rate, regime, regime_changed, change_total, sample_total
   output logic [((2*RATE_WIDTH+2*crd_pkg::COUNT_WIDTH+crd_pkg::REGIME_WIDTH+8)/8)*8-1:0]
                                                      rsp_tdata,
   input  logic                                       csr_wr_en,
   input  logic [crd_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [crd_pkg::CSR_DATA_WIDTH-1:0]         csr_wdata
);

   localparam int W      = RATE_WIDTH;
   localparam int OUT_W  = ((2*W + 2*crd_pkg::COUNT_WIDTH + crd_pkg::REGIME_WIDTH + 8) / 8) * 8;
   localparam int CAP_W  = (FRAC_BITS + 1 > crd_pkg::ALPHA_WIDTH) ? FRAC_BITS + 1
                                                                   : crd_pkg::ALPHA_WIDTH;
   localparam int CMP_W  = ((W > crd_pkg::THRESHOLD_WIDTH + 1) ? W
                                                               : crd_pkg::THRESHOLD_WIDTH + 1) + 1;
   localparam int CNT_W  = crd_pkg::COUNT_WIDTH;

   localparam logic [CAP_W-1:0]    ALPHA_ONE = CAP_W'(1) << FRAC_BITS;
   localparam logic signed [W+1:0] RATE_MAX  = $signed({3'b000, {(W-1){1'b1}}});
   localparam logic signed [W+1:0] RATE_MIN  = $signed({3'b111, {(W-1){1'b0}}});

   typedef enum logic [2:0] {
      S_IDLE,
      S_RAW1,
      S_DIFF,
      S_MUL,
      S_RAW2,
      S_CLASS,
      S_OUT
   } state_type;

   state_type                               state_ff;
   logic                                    phase_ff;

   logic [crd_pkg::ALPHA_WIDTH-1:0]         alpha_first_ff;
   logic [crd_pkg::ALPHA_WIDTH-1:0]         alpha_second_ff;
   logic [crd_pkg::THRESHOLD_WIDTH-1:0]     threshold_ff;
   logic [crd_pkg::WARMUP_WIDTH-1:0]        warmup_ff;

   logic signed [crd_pkg::SAMPLE_WIDTH-1:0] x_ff;
   logic signed [crd_pkg::SAMPLE_WIDTH-1:0] last_ff;
   logic                                    seeded_sample_ff;
   logic                                    seeded_rate_ff;
   logic signed [W-1:0]                     sf_ff;
   logic signed [W-1:0]                     ss_ff;
   logic signed [W-1:0]                     nf_ff;
   logic signed [W-1:0]                     raw_ff;
   crd_pkg::regime_type                     regime_ff;
   logic                                    changed_ff;
   logic [CNT_W-1:0]                        samples_ff;
   logic [CNT_W-1:0]                        changes_ff;

   logic                                    rsp_valid_ff;
   logic [OUT_W-1:0]                        rsp_data_ff;
   logic                                    rsp_load;

   // shared add / saturate unit
   logic signed [W:0]                       add_a;
   logic signed [W:0]                       add_b;
   logic                                    add_sub;
   logic signed [W+1:0]                     add_sum;
   logic signed [W-1:0]                     add_sat;
   logic signed [W:0]                       add_diff;

   logic [crd_pkg::ALPHA_WIDTH-1:0]         alpha_raw;
   logic [crd_pkg::ALPHA_WIDTH-1:0]         alpha_cap;
   logic                                    mul_start;
   logic                                    mul_done;
   logic signed [W:0]                       mul_step;

   logic signed [CMP_W-1:0]                 ss_cmp;
   logic signed [CMP_W-1:0]                 thr_cmp;
   crd_pkg::regime_type                     regime_in;

   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      case (state_ff)
         S_RAW1: begin
            add_a   = (W + 1)'(x_ff);
            add_b   = (W + 1)'(last_ff);
            add_sub = 1'b1;
         end
         S_DIFF: begin
            add_a   = (W + 1)'(raw_ff);
            add_b   = phase_ff ? (W + 1)'(ss_ff) : (W + 1)'(sf_ff);
            add_sub = 1'b1;
         end
         S_MUL: begin
            add_a   = phase_ff ? (W + 1)'(ss_ff) : (W + 1)'(sf_ff);
            add_b   = mul_step;
         end
         S_RAW2: begin
            add_a   = (W + 1)'(nf_ff);
            add_b   = (W + 1)'(sf_ff);
            add_sub = 1'b1;
         end
         default: begin
            add_a   = '0;
         end
      endcase
   end

   assign add_sum = (W + 2)'(add_a) + (add_sub ? -((W + 2)'(add_b)) : (W + 2)'(add_b));

   always_comb begin
      if (add_sum > RATE_MAX) begin
         add_sat = RATE_MAX[W-1:0];
      end else if (add_sum < RATE_MIN) begin
         add_sat = RATE_MIN[W-1:0];
      end else begin
         add_sat = add_sum[W-1:0];
      end
   end

   // differences keep one extra bit, unless the rate already fills 64 bits
   assign add_diff = (RATE_WIDTH >= 64) ? (W + 1)'(add_sat) : add_sum[W:0];

   assign alpha_raw = phase_ff ? alpha_second_ff : alpha_first_ff;
   assign alpha_cap = (CAP_W'(alpha_raw) > ALPHA_ONE) ? crd_pkg::ALPHA_WIDTH'(ALPHA_ONE)
                                                      : alpha_raw;
   assign mul_start = (state_ff == S_DIFF);

   crd_mul #(
      .RATE_WIDTH (RATE_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .diff  (add_diff),
      .alpha (alpha_cap),
      .done  (mul_done),
      .step  (mul_step)
   );

   assign ss_cmp  = CMP_W'(ss_ff);
   assign thr_cmp = CMP_W'($signed({1'b0, threshold_ff}));

   always_comb begin
      regime_in = crd_pkg::REGIME_STABLE;
      if (samples_ff >= CNT_W'(warmup_ff)) begin
         if (ss_cmp > thr_cmp) begin
            regime_in = crd_pkg::REGIME_ACCEL;
         end else if (ss_cmp < -thr_cmp) begin
            regime_in = crd_pkg::REGIME_DECEL;
         end
      end
   end

   // result register takes a new transaction when empty or draining this cycle, and no csr write is under way
   assign rsp_load = (state_ff == S_OUT) && !csr_wr_en && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         phase_ff         <= 1'b0;
         alpha_first_ff   <= crd_pkg::ALPHA_FIRST_RESET;
         alpha_second_ff  <= crd_pkg::ALPHA_SECOND_RESET;
         threshold_ff     <= crd_pkg::THRESHOLD_RESET;
         warmup_ff        <= crd_pkg::WARMUP_RESET;
         last_ff          <= '0;
         seeded_sample_ff <= 1'b0;
         seeded_rate_ff   <= 1'b0;
         sf_ff            <= '0;
         ss_ff            <= '0;
         regime_ff        <= crd_pkg::REGIME_STABLE;
         changed_ff       <= 1'b0;
         samples_ff       <= '0;
         changes_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (crd_pkg::csr_index_type'(csr_index))
               crd_pkg::CSR_ALPHA_FIRST:  alpha_first_ff  <= csr_wdata[crd_pkg::ALPHA_WIDTH-1:0];
               crd_pkg::CSR_ALPHA_SECOND: alpha_second_ff <= csr_wdata[crd_pkg::ALPHA_WIDTH-1:0];
               crd_pkg::CSR_THRESHOLD:    threshold_ff    <= csr_wdata;
               crd_pkg::CSR_WARMUP:       warmup_ff       <= csr_wdata[crd_pkg::WARMUP_WIDTH-1:0];
               default:                   warmup_ff       <= warmup_ff;
            endcase
            last_ff          <= '0;
            seeded_sample_ff <= 1'b0;
            seeded_rate_ff   <= 1'b0;
            sf_ff            <= '0;
            ss_ff            <= '0;
            regime_ff        <= crd_pkg::REGIME_STABLE;
            changed_ff       <= 1'b0;
            samples_ff       <= '0;
            changes_ff       <= '0;
         end else begin
            case (state_ff)
               S_IDLE: begin
                  if (req_tvalid && req_tready) begin
                     x_ff <= req_tdata;
                     if (req_tuser == crd_pkg::OP_CLEAR) begin
                        last_ff          <= '0;
                        seeded_sample_ff <= 1'b0;
                        seeded_rate_ff   <= 1'b0;
                        sf_ff            <= '0;
                        ss_ff            <= '0;
                        regime_ff        <= crd_pkg::REGIME_STABLE;
                        changed_ff       <= 1'b0;
                        samples_ff       <= '0;
                        changes_ff       <= '0;
                        state_ff         <= S_OUT;
                     end else begin
                        if (samples_ff != '1) begin
                           samples_ff <= samples_ff + 1'b1;
                        end
                        if (!seeded_sample_ff) begin
                           // first sample only seeds
                           last_ff          <= req_tdata;
                           sf_ff            <= '0;
                           ss_ff            <= '0;
                           seeded_sample_ff <= 1'b1;
                           changed_ff       <= 1'b0;
                           state_ff         <= S_OUT;
                        end else begin
                           state_ff <= S_RAW1;
                        end
                     end
                  end
               end
               S_RAW1: begin
                  last_ff  <= x_ff;
                  raw_ff   <= add_sat;
                  phase_ff <= 1'b0;
                  if (!seeded_rate_ff) begin
                     sf_ff          <= add_sat;
                     seeded_rate_ff <= 1'b1;
                     changed_ff     <= 1'b0;
                     state_ff       <= S_OUT;
                  end else begin
                     state_ff <= S_DIFF;
                  end
               end
               S_DIFF: begin
                  state_ff <= S_MUL;
               end
               S_MUL: begin
                  if (mul_done) begin
                     if (!phase_ff) begin
                        nf_ff    <= add_sat;
                        state_ff <= S_RAW2;
                     end else begin
                        ss_ff    <= add_sat;
                        state_ff <= S_CLASS;
                     end
                  end
               end
               S_RAW2: begin
                  raw_ff   <= add_sat;
                  phase_ff <= 1'b1;
                  state_ff <= S_DIFF;
               end
               S_CLASS: begin
                  sf_ff      <= nf_ff;
                  regime_ff  <= regime_in;
                  changed_ff <= (regime_in != regime_ff);
                  if ((regime_in != regime_ff) && (changes_ff != '1)) begin
                     changes_ff <= changes_ff + 1'b1;
                  end
                  state_ff <= S_OUT;
               end
               S_OUT: begin
                  if (rsp_load) begin
                     rsp_data_ff  <= OUT_W'({samples_ff, changes_ff, changed_ff, regime_ff,
                                             ss_ff, sf_ff});
                     state_ff     <= S_IDLE;
                  end
               end
               default: begin
                  state_ff <= S_IDLE;
               end
            endcase
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !reset && !csr_wr_en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input ready straight after an accepted transaction");

   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MUL))
      else $error("multiplier finished outside the multiply state");

   a_changes_bounded: assert property (@(posedge clock) disable iff (reset)
      changes_ff <= samples_ff)
      else $error("more regime changes than samples");

   a_change_needs_history: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT) && changed_ff) |-> (samples_ff >= CNT_W'(3)))
      else $error("regime change flagged before two differences exist");

endmodule
